[rtl/core/joint_stand_interpolator_macros.svh]
// assertion macros for the joint stand interpolator
`ifndef JOINT_STAND_INTERPOLATOR_MACROS_SVH
`define JOINT_STAND_INTERPOLATOR_MACROS_SVH
// implication checked on every edge out of reset
`define JSI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: label failed");
// next-cycle implication
`define JSI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: label failed");
`endif

[rtl/core/jsi_pkg.sv]
// shared types and constants of the joint stand interpolator
package jsi_pkg;
    localparam int unsigned JOINTS_DEF = 23;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] CMD_CAPTURE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;
    localparam logic [1:0] CMD_BUTTON  = 2'd3;

    localparam logic [1:0] BTN_OTHER   = 2'd0;
    localparam logic [1:0] BTN_PASSIVE = 2'd1;
    localparam logic [1:0] BTN_ADVANCE = 2'd2;
    localparam logic [1:0] BTN_SELECT  = 2'd3;

    localparam logic [2:0] NS_STAY    = 3'd0;
    localparam logic [2:0] NS_PASSIVE = 3'd1;
    localparam logic [2:0] NS_LOCO    = 3'd2;
    localparam logic [2:0] NS_AMP     = 3'd3;
    localparam logic [2:0] NS_EXIT    = 3'd4;

    localparam logic [1:0] VD_OK       = 2'd0;
    localparam logic [1:0] VD_NOT_DONE = 2'd1;
    localparam logic [1:0] VD_UNSTABLE = 2'd2;

    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_SMOOTH_MODE = 2'd1;
    localparam logic [1:0] REG_ERROR_LIMIT = 2'd2;
    localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

    // job handed from front to back
    typedef struct packed {
        logic        is_tick;
        logic [16:0] blend;
        logic        done;
        logic        smooth;
        logic [2:0]  next_state;
        logic [1:0]  verdict;
        logic [4:0]  worst_joint;
    } job_t;
endpackage

[rtl/core/jsi_front.sv]
// front part: tables, phase, trackers, decisions and job queue
module jsi_front #(
    parameter int unsigned JOINTS = jsi_pkg::JOINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [4:0]          joint,
    input  logic                first,
    input  logic signed [15:0]  position,
    input  logic signed [15:0]  goal,
    input  logic signed [15:0]  lower_limit,
    input  logic signed [15:0]  upper_limit,
    input  logic signed [15:0]  speed,
    input  logic [1:0]          button,
    input  logic [16:0]         phase_step,
    input  logic                smooth_mode,
    input  logic [14:0]         error_limit,
    input  logic [14:0]         speed_limit,
    output logic                job_valid,
    output jsi_pkg::job_t       job,
    input  logic                job_take,
    input  logic                tables_busy,
    input  logic [4:0]          rd_idx,
    output logic signed [15:0]  rd_start,
    output logic signed [15:0]  rd_goal,
    output logic signed [15:0]  rd_lower,
    output logic signed [15:0]  rd_upper
);
    import jsi_pkg::*;
    localparam int unsigned IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic signed [15:0] start_mem [JOINTS];
    logic signed [15:0] goal_mem  [JOINTS];
    logic signed [15:0] lower_mem [JOINTS];
    logic signed [15:0] upper_mem [JOINTS];

    // the smoothstep multiplies run in a small pipe: p*p, then *t
    typedef enum logic [3:0] {
        F_IDLE = 4'b0001, F_SQ = 4'b0010, F_MUL = 4'b0100, F_PUSH = 4'b1000
    } fst_t;
    fst_t st_reg, st_next;

    logic [16:0] phase_reg;
    logic        complete_reg;
    logic [15:0] worst_error_reg, peak_speed_reg;
    logic [4:0]  worst_index_reg;
    logic [33:0] sq_reg;
    logic [50:0] prod_reg;
    logic [16:0] bl_reg;
    logic        sm_reg;

    // two-entry job queue
    job_t   q_reg [2];
    logic   q_wr_reg, q_rd_reg;
    logic [1:0] q_cnt_reg;
    logic   push;
    job_t   push_job;

    logic accept;
    // a capture must not overwrite tables that a queued or running tick still reads
    assign in_stall = (st_reg != F_IDLE) || (q_cnt_reg == 2'd2)
                      || (cmd == CMD_CAPTURE && (q_cnt_reg != 2'd0 || tables_busy));
    assign accept   = in_valid && !in_stall;
    assign job_valid = (q_cnt_reg != 2'd0);
    assign job = q_reg[q_rd_reg];

    logic jok;
    assign jok = ({27'd0, joint} < JOINTS);

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_CAPTURE && jok)
        begin
            start_mem[joint[IW-1:0]] <= position;
            goal_mem[joint[IW-1:0]]  <= goal;
            lower_mem[joint[IW-1:0]] <= lower_limit;
            upper_mem[joint[IW-1:0]] <= upper_limit;
        end
    end

    assign rd_start = start_mem[rd_idx[IW-1:0]];
    assign rd_goal  = goal_mem[rd_idx[IW-1:0]];
    assign rd_lower = lower_mem[rd_idx[IW-1:0]];
    assign rd_upper = upper_mem[rd_idx[IW-1:0]];

    // sample error against stored goal
    logic signed [16:0] diff;
    logic [15:0] err_abs, spd_abs;
    logic signed [15:0] g_samp;
    assign g_samp = goal_mem[joint[IW-1:0]];
    assign diff = {position[15], position} - {g_samp[15], g_samp};
    always_comb
    begin
        logic [16:0] a;
        a = diff[16] ? 17'(-diff) : 17'(diff);
        err_abs = a[15:0];
        spd_abs = speed[15] ? 16'(-speed) : 16'(speed);
    end

    // tick phase update
    logic [17:0] ph_sum;
    logic        ph_done;
    assign ph_sum  = {1'b0, phase_reg} + {1'b0, phase_step};
    assign ph_done = complete_reg || (ph_sum >= {1'b0, ONE_Q16});

    // smoothstep rounding
    logic [50:0] rnd;
    logic [16:0] sb;
    assign rnd = prod_reg + (51'd1 << 31);
    assign sb  = (rnd[50:32] > 19'(ONE_Q16)) ? ONE_Q16 : rnd[48:32];

    logic [2:0] dec_ns;
    logic [1:0] dec_vd;
    always_comb
    begin
        dec_ns = NS_STAY;
        dec_vd = VD_OK;
        unique case (button)
            BTN_PASSIVE: dec_ns = NS_PASSIVE;
            BTN_SELECT:  dec_ns = NS_EXIT;
            BTN_ADVANCE:
            begin
                priority if (!smooth_mode) dec_ns = NS_AMP;
                else if (!complete_reg) dec_vd = VD_NOT_DONE;
                else if (worst_error_reg > {1'b0, error_limit}
                         || peak_speed_reg > {1'b0, speed_limit}) dec_vd = VD_UNSTABLE;
                else dec_ns = NS_LOCO;
            end
            default: dec_ns = NS_STAY;
        endcase
    end

    always_comb
    begin
        st_next  = st_reg;
        push     = 1'b0;
        push_job = '0;
        unique case (st_reg)
            F_IDLE:
            begin
                if (accept && cmd == CMD_TICK)
                    st_next = F_SQ;
                else if (accept && cmd == CMD_BUTTON)
                begin
                    push = 1'b1;
                    push_job.is_tick     = 1'b0;
                    push_job.done        = complete_reg;
                    push_job.next_state  = dec_ns;
                    push_job.verdict     = dec_vd;
                    push_job.worst_joint = worst_index_reg;
                end
            end
            F_SQ:  st_next = F_MUL;
            F_MUL: st_next = F_PUSH;
            F_PUSH:
            begin
                push = 1'b1;
                st_next = F_IDLE;
                push_job.is_tick = 1'b1;
                push_job.blend   = sm_reg ? sb : phase_reg;
                push_job.done    = complete_reg;
                push_job.smooth  = sm_reg;
            end
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= phase_reg * phase_reg;
        prod_reg <= 51'(sq_reg) * 51'(18'(3 * 65536) - {phase_reg, 1'b0});
        if (push)
            q_reg[q_wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
            phase_reg <= '0;
            complete_reg <= 1'b0;
            worst_error_reg <= '0;
            peak_speed_reg <= '0;
            worst_index_reg <= '0;
            sm_reg <= 1'b0;
            q_wr_reg <= 1'b0;
            q_rd_reg <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (accept)
            begin
                unique case (cmd)
                    CMD_CAPTURE:
                        if (first)
                        begin
                            phase_reg <= '0;
                            complete_reg <= 1'b0;
                        end
                    CMD_TICK:
                    begin
                        complete_reg <= ph_done;
                        phase_reg <= ph_done ? ONE_Q16 : ph_sum[16:0];
                        sm_reg <= smooth_mode;
                    end
                    CMD_SAMPLE:
                    begin
                        logic [15:0] we, ps;
                        logic [4:0]  wi;
                        we = first ? 16'd0 : worst_error_reg;
                        ps = first ? 16'd0 : peak_speed_reg;
                        wi = first ? 5'd0 : worst_index_reg;
                        if (jok)
                        begin
                            if (err_abs > we)
                            begin
                                we = err_abs;
                                wi = joint;
                            end
                            if (spd_abs > ps)
                                ps = spd_abs;
                        end
                        worst_error_reg <= we;
                        peak_speed_reg <= ps;
                        worst_index_reg <= wi;
                    end
                    default: ;
                endcase
            end
            if (push)
                q_wr_reg <= !q_wr_reg;
            if (job_take)
                q_rd_reg <= !q_rd_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(job_take);
        end
    end

    `include "joint_stand_interpolator_macros.svh"
    `JSI_ASSERT_IMP(a_q_no_overflow, push, q_cnt_reg != 2'd2)
    `JSI_ASSERT_IMP(a_take_valid, job_take, job_valid)
    `JSI_ASSERT_IMP(a_phase_max, 1'b1, phase_reg <= ONE_Q16)
    `JSI_ASSERT_NXT(a_tick_pipe, st_reg == F_SQ, st_reg == F_MUL)
endmodule

[rtl/core/jsi_back.sv]
// back part: walks the joints of a tick job and drives the result register
module jsi_back #(
    parameter int unsigned JOINTS = jsi_pkg::JOINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  jsi_pkg::job_t       job,
    output logic                job_take,
    output logic                tables_busy,
    output logic [4:0]          rd_idx,
    input  logic signed [15:0]  rd_start,
    input  logic signed [15:0]  rd_goal,
    input  logic signed [15:0]  rd_lower,
    input  logic signed [15:0]  rd_upper,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [4:0]          out_joint,
    output logic signed [15:0]  setpoint,
    output logic [16:0]         blend,
    output logic                last,
    output logic                done_res,
    output logic [2:0]          next_state,
    output logic [1:0]          verdict,
    output logic [4:0]          worst_joint
);
    import jsi_pkg::*;

    // per joint: mult stage, then sum/clamp into output
    logic        busy_reg, m_v_reg, ov_reg;
    logic [4:0]  idx_reg, m_idx_reg;
    logic signed [34:0] m1_reg, m2_reg;
    logic signed [15:0] m_lo_reg, m_hi_reg;

    logic        free;
    assign free = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign rd_idx = idx_reg;
    // tables are read only while joints are still being issued
    assign tables_busy = busy_reg;

    logic last_idx;
    assign last_idx = ({27'd0, idx_reg} == JOINTS - 1);

    // issue a joint when the mult stage can move
    logic m_move, issue;
    assign m_move = !m_v_reg || free;
    assign issue = busy_reg && m_move;
    assign job_take = job_valid && !busy_reg && (job.is_tick ? 1'b1 : free) && !m_v_reg;

    job_t cur_reg;

    logic signed [36:0] acc;
    logic signed [20:0] r;
    logic signed [15:0] x, xc;
    assign acc = 37'(m1_reg) + 37'(m2_reg) + 37'sd32768;
    assign r = acc[36:16];
    always_comb
    begin
        priority if (r > 21'sd32767) x = 16'sh7fff;
        else if (r < -21'sd32768) x = 16'sh8000;
        else x = r[15:0];
        xc = x;
        if (cur_reg.smooth)
        begin
            if (xc < m_lo_reg) xc = m_lo_reg;
            if (xc > m_hi_reg) xc = m_hi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m1_reg <= $signed({1'b0, 17'(ONE_Q16 - cur_reg.blend)}) * 35'(rd_start);
            m2_reg <= $signed({1'b0, cur_reg.blend}) * 35'(rd_goal);
            m_lo_reg <= rd_lower;
            m_hi_reg <= rd_upper;
            m_idx_reg <= idx_reg;
        end
        if (job_take)
            cur_reg <= job;
        if (job_take && !job.is_tick)
        begin
            kind <= 1'b1;
            out_joint <= '0;
            setpoint <= '0;
            blend <= '0;
            last <= 1'b0;
            done_res <= job.done;
            next_state <= job.next_state;
            verdict <= job.verdict;
            worst_joint <= job.worst_joint;
        end
        else if (m_v_reg && free)
        begin
            kind <= 1'b0;
            out_joint <= m_idx_reg;
            setpoint <= xc;
            blend <= cur_reg.blend;
            last <= ({27'd0, m_idx_reg} == JOINTS - 1);
            done_res <= cur_reg.done;
            next_state <= NS_STAY;
            verdict <= VD_OK;
            worst_joint <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            m_v_reg <= 1'b0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (job_take && job.is_tick)
            begin
                busy_reg <= 1'b1;
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 5'd1;
                if (last_idx)
                    busy_reg <= 1'b0;
            end
            if (m_move)
                m_v_reg <= issue;
            if (free)
                ov_reg <= (m_v_reg) || (job_take && !job.is_tick);
        end
    end

    `include "joint_stand_interpolator_macros.svh"
    `JSI_ASSERT_IMP(a_no_take_busy, job_take, !busy_reg)
    `JSI_ASSERT_IMP(a_idx_range, busy_reg, {27'd0, idx_reg} < JOINTS)
    `JSI_ASSERT_NXT(a_out_hold, ov_reg && out_stall, ov_reg)
endmodule

[rtl/core/joint_stand_interpolator.sv]
// top level of the joint stand interpolator
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | cmd joint first position goal limits speed button
//  out     | out_valid / out_stall  | kind out_joint setpoint blend last done_res ...
//  cfg     | cfg_valid / cfg_ready  | cfg_index cfg_data
// capture, sample and button items leave the front idle; a capture waits while a tick reads tables
// a tick passes front states F_SQ, F_MUL, F_PUSH for the smoothstep multiplies, then
// the back part walks the joints one per cycle through one multiply stage unless stalled
// a two-entry job queue lets the front accept while the back drains
// out_stall holds the result register and backs up the joint walk
// reset clears control state; joint tables are undefined until captured
module joint_stand_interpolator #(
    parameter int unsigned JOINTS = jsi_pkg::JOINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [4:0]          joint,
    input  logic                first,
    input  logic signed [15:0]  position,
    input  logic signed [15:0]  goal,
    input  logic signed [15:0]  lower_limit,
    input  logic signed [15:0]  upper_limit,
    input  logic signed [15:0]  speed,
    input  logic [1:0]          button,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [4:0]          out_joint,
    output logic signed [15:0]  setpoint,
    output logic [16:0]         blend,
    output logic                last,
    output logic                done_res,
    output logic [2:0]          next_state,
    output logic [1:0]          verdict,
    output logic [4:0]          worst_joint
);
    import jsi_pkg::*;

    logic [16:0] phase_step_reg;
    logic        smooth_mode_reg;
    logic [14:0] error_limit_reg, speed_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= 17'd66;
            smooth_mode_reg <= 1'b1;
            error_limit_reg <= 15'd614;
            speed_limit_reg <= 15'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:  phase_step_reg <= cfg_data;
                REG_SMOOTH_MODE: smooth_mode_reg <= cfg_data[0];
                REG_ERROR_LIMIT: error_limit_reg <= cfg_data[14:0];
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    logic job_valid, job_take, tables_busy;
    job_t job;
    logic [4:0] rd_idx;
    logic signed [15:0] rd_start, rd_goal, rd_lower, rd_upper;

    jsi_front #(.JOINTS(JOINTS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .joint, .first, .position,
        .goal, .lower_limit, .upper_limit, .speed, .button,
        .phase_step(phase_step_reg), .smooth_mode(smooth_mode_reg),
        .error_limit(error_limit_reg), .speed_limit(speed_limit_reg),
        .job_valid, .job, .job_take, .tables_busy, .rd_idx, .rd_start, .rd_goal,
        .rd_lower, .rd_upper
    );

    jsi_back #(.JOINTS(JOINTS)) u_back (
        .clk, .rst_n, .job_valid, .job, .job_take, .tables_busy, .rd_idx, .rd_start,
        .rd_goal, .rd_lower, .rd_upper, .out_valid, .out_stall, .kind,
        .out_joint, .setpoint, .blend, .last, .done_res, .next_state,
        .verdict, .worst_joint
    );
endmodule

[test/joint_stand_interpolator_tb.sv]
// self-checking testbench of the joint stand interpolator with its own trajectory predictor
module joint_stand_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jsi_pkg::*;

    localparam int NJ = JOINTS_DEF;

    typedef struct {
        logic [1:0]         cmd;
        logic [4:0]         joint;
        logic               first;
        logic signed [15:0] position;
        logic signed [15:0] goal;
        logic signed [15:0] lower_limit;
        logic signed [15:0] upper_limit;
        logic signed [15:0] speed;
        logic [1:0]         button;
    } stim_t;

    typedef struct {
        logic               kind;
        logic [4:0]         out_joint;
        logic signed [15:0] setpoint;
        logic [16:0]        blend;
        logic               last;
        logic               done_res;
        logic [2:0]         next_state;
        logic [1:0]         verdict;
        logic [4:0]         worst_joint;
    } result_t;

    typedef struct {
        stim_t      s;
        bit         typed;
        logic       done_res;
        logic [2:0] next_state;
        logic [1:0] verdict;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [4:0] joint = '0;
    logic first = 1'b0;
    logic signed [15:0] position = '0;
    logic signed [15:0] goal = '0;
    logic signed [15:0] lower_limit = '0;
    logic signed [15:0] upper_limit = '0;
    logic signed [15:0] speed = '0;
    logic [1:0] button = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind;
    logic [4:0] out_joint;
    logic signed [15:0] setpoint;
    logic [16:0] blend;
    logic last;
    logic done_res;
    logic [2:0] next_state;
    logic [1:0] verdict;
    logic [4:0] worst_joint;

    joint_stand_interpolator u_dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [16:0]        step_q16 = 17'd66;
    logic               smooth_on = 1'b1;
    logic [14:0]        err_lim = 15'd614;
    logic [14:0]        spd_lim = 15'd256;
    logic signed [15:0] start_tab [NJ];
    logic signed [15:0] goal_tab [NJ];
    logic signed [15:0] lower_tab [NJ];
    logic signed [15:0] upper_tab [NJ];
    logic [16:0]        phase_q16 = '0;
    logic               reached = 1'b0;
    logic [15:0]        worst_err = '0;
    logic [15:0]        peak_spd = '0;
    logic [4:0]         worst_idx = '0;

    result_t pending_results [$];
    int  fail_count = 0;
    bit  calm = 1'b0;

    function automatic logic [16:0] smoothstep_q16(logic [16:0] p);
        longint unsigned p2;
        longint unsigned t;
        longint unsigned b;
        p2 = longint'(p) * longint'(p);
        t = 3 * 65536 - 2 * longint'(p);
        b = (p2 * t + (64'd1 << 31)) >> 32;
        return (b > 65536) ? ONE_Q16 : b[16:0];
    endfunction

    function automatic logic signed [15:0] lerp_q12(logic signed [15:0] s,
                                                    logic signed [15:0] g,
                                                    logic [16:0] b);
        longint acc;
        longint r;
        acc = (65536 - longint'(b)) * longint'(s) + longint'(b) * longint'(g) + 32768;
        r = acc >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic interpolate_item(stim_t it);
        result_t r;
        logic [16:0] b;
        logic signed [15:0] x;
        int d;
        int v;
        logic [17:0] ph;
        r = '{default: '0};
        case (it.cmd)
            CMD_CAPTURE:
            begin
                if (it.first)
                begin
                    phase_q16 = '0;
                    reached = 1'b0;
                end
                if (it.joint < NJ)
                begin
                    start_tab[it.joint] = it.position;
                    goal_tab[it.joint] = it.goal;
                    lower_tab[it.joint] = it.lower_limit;
                    upper_tab[it.joint] = it.upper_limit;
                end
            end
            CMD_TICK:
            begin
                ph = phase_q16 + step_q16;
                if (ph >= 18'(ONE_Q16)) reached = 1'b1;
                phase_q16 = reached ? ONE_Q16 : ph[16:0];
                b = smooth_on ? smoothstep_q16(phase_q16) : phase_q16;
                for (int i = 0; i < NJ; i++)
                begin
                    x = lerp_q12(start_tab[i], goal_tab[i], b);
                    if (smooth_on)
                    begin
                        if (x < lower_tab[i]) x = lower_tab[i];
                        if (x > upper_tab[i]) x = upper_tab[i];
                    end
                    r.kind = 1'b0;
                    r.out_joint = i[4:0];
                    r.setpoint = x;
                    r.blend = b;
                    r.last = (i == NJ - 1);
                    r.done_res = reached;
                    pending_results.push_back(r);
                end
            end
            CMD_SAMPLE:
            begin
                if (it.first)
                begin
                    worst_err = '0;
                    peak_spd = '0;
                    worst_idx = '0;
                end
                if (it.joint < NJ)
                begin
                    d = int'(it.position) - int'(goal_tab[it.joint]);
                    v = int'(it.speed);
                    if (d < 0) d = -d;
                    if (v < 0) v = -v;
                    if (d > worst_err)
                    begin
                        worst_err = d[15:0];
                        worst_idx = it.joint;
                    end
                    if (v > peak_spd) peak_spd = v[15:0];
                end
            end
            default:
            begin
                r.kind = 1'b1;
                r.done_res = reached;
                r.next_state = NS_STAY;
                r.verdict = VD_OK;
                r.worst_joint = worst_idx;
                if (it.button == BTN_PASSIVE) r.next_state = NS_PASSIVE;
                else if (it.button == BTN_SELECT) r.next_state = NS_EXIT;
                else if (it.button == BTN_ADVANCE)
                begin
                    if (!smooth_on) r.next_state = NS_AMP;
                    else if (!reached) r.verdict = VD_NOT_DONE;
                    else if (worst_err > err_lim || peak_spd > spd_lim) r.verdict = VD_UNSTABLE;
                    else r.next_state = NS_LOCO;
                end
                pending_results.push_back(r);
            end
        endcase
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // drive one item, hold it until accepted
    task automatic send_row(row_t rw);
        result_t r;
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= rw.s.cmd;
        joint <= rw.s.joint;
        first <= rw.s.first;
        position <= rw.s.position;
        goal <= rw.s.goal;
        lower_limit <= rw.s.lower_limit;
        upper_limit <= rw.s.upper_limit;
        speed <= rw.s.speed;
        button <= rw.s.button;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (rw.typed)
        begin
            interpolate_item(rw.s);
            void'(pending_results.pop_back());
            r = '{default: '0};
            r.kind = 1'b1;
            r.done_res = rw.done_res;
            r.next_state = rw.next_state;
            r.verdict = rw.verdict;
            pending_results.push_back(r);
        end
        else
            interpolate_item(rw.s);
        @(negedge clk);
    endtask

    task automatic send_stim(stim_t s);
        row_t rw;
        rw = '{s: s, typed: 1'b0, default: '0};
        send_row(rw);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PHASE_STEP:  step_q16 = data;
            REG_SMOOTH_MODE: smooth_on = data[0];
            REG_ERROR_LIMIT: err_lim = data[14:0];
            default:         spd_lim = data[14:0];
        endcase
        @(negedge clk);
    endtask

    function automatic stim_t mk(logic [1:0] c, int j, int f, int p, int g,
                                 int lo, int hi, int sp, int bt);
        stim_t s;
        s.cmd = c;
        s.joint = j[4:0];
        s.first = f[0];
        s.position = p[15:0];
        s.goal = g[15:0];
        s.lower_limit = lo[15:0];
        s.upper_limit = hi[15:0];
        s.speed = sp[15:0];
        s.button = bt[1:0];
        return s;
    endfunction

    function automatic stim_t random_stim();
        stim_t s;
        int sel;
        s = mk(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
        sel = $urandom_range(0, 99);
        s.first = ($urandom_range(0, 9) == 0);
        if (sel < 25) s.cmd = CMD_CAPTURE;
        else if (sel < 55) s.cmd = CMD_TICK;
        else if (sel < 80) s.cmd = CMD_SAMPLE;
        else s.cmd = CMD_BUTTON;
        s.joint = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, NJ - 1))
                                              : 5'($urandom_range(NJ, 31));
        if (s.cmd == CMD_CAPTURE && $urandom_range(0, 3) == 0)
        begin
            // narrow clamp window, sometimes inverted
            s.lower_limit = s.goal - 16'($urandom_range(0, 2000));
            s.upper_limit = s.goal + 16'($urandom_range(0, 2000)) - 16'(1000);
        end
        if (s.cmd == CMD_SAMPLE && s.joint < NJ && $urandom_range(0, 1))
        begin
            // stable joint close to its goal
            s.position = goal_tab[s.joint] + 16'($urandom_range(0, 400)) - 16'(200);
            s.speed = 16'($urandom_range(0, 200)) - 16'(100);
        end
        if (s.cmd == CMD_BUTTON && $urandom_range(0, 1)) s.button = BTN_ADVANCE;
        return s;
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_v,
                               logic signed [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result side: random stalls, compare every accepted item
    initial
    begin
        result_t e;
        int n;
        @(posedge rst_n);
        forever
        begin
            n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("kind", e.kind, kind);
                check_field("out_joint", e.out_joint, out_joint);
                check_field("setpoint", e.setpoint, setpoint);
                check_field("blend", e.blend, blend);
                check_field("last", e.last, last);
                check_field("done_res", e.done_res, done_res);
                check_field("next_state", e.next_state, next_state);
                check_field("verdict", e.verdict, verdict);
                check_field("worst_joint", e.worst_joint, worst_joint);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        row_t rows [$];
        row_t rw;
        logic [16:0] steps [6];
        logic        modes [6];
        logic [14:0] elims [6];
        logic [14:0] slims [6];

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decisions straight after reset
        rw = '{s: mk(CMD_BUTTON, 0, 0, 0, 0, 0, 0, 0, BTN_OTHER), typed: 1'b1,
               done_res: 1'b0, next_state: NS_STAY, verdict: VD_OK};
        rows.push_back(rw);
        rw.s.button = BTN_PASSIVE; rw.next_state = NS_PASSIVE;
        rows.push_back(rw);
        rw.s.button = BTN_SELECT; rw.next_state = NS_EXIT;
        rows.push_back(rw);
        rw.s.button = BTN_ADVANCE; rw.next_state = NS_STAY; rw.verdict = VD_NOT_DONE;
        rows.push_back(rw);
        foreach (rows[i]) send_row(rows[i]);

        // every joint captured before anything reads the tables
        send_stim(mk(CMD_CAPTURE, 0, 1, -32768, 32767, -32768, 32767, 0, 0));
        for (int i = 1; i < NJ - 1; i++)
            send_stim(mk(CMD_CAPTURE, i, 0, $urandom, $urandom, $urandom, $urandom, 0, 0));
        send_stim(mk(CMD_CAPTURE, NJ - 1, 0, 32767, -32768, -32768, 32767, 0, 0));

        send_stim(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send_stim(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send_stim(mk(CMD_SAMPLE, 0, 1, 32767, 0, 0, 0, -32768, 0));
        send_stim(mk(CMD_SAMPLE, NJ - 1, 0, -32768, 0, 0, 0, 32767, 0));
        send_stim(mk(CMD_SAMPLE, 31, 1, 100, 0, 0, 0, 100, 0));
        send_stim(mk(CMD_CAPTURE, 31, 1, 5, 5, 5, 5, 0, 0));
        send_stim(mk(CMD_CAPTURE, 5, 0, 1000, -1000, 500, -500, 0, 0));
        send_stim(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
        send_stim(mk(CMD_BUTTON, 0, 0, 0, 0, 0, 0, 0, BTN_ADVANCE));
        send_stim(mk(CMD_BUTTON, 0, 0, 0, 0, 0, 0, 0, BTN_OTHER));
        drain();

        steps = '{17'd65536, 17'd1, 17'($urandom_range(1, 8000)), 17'd20000,
                  17'($urandom_range(1, 65536)), 17'd65535};
        modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        elims = '{15'h7fff, 15'd0, 15'd0, 15'($urandom), 15'($urandom), 15'h7fff};
        slims = '{15'h7fff, 15'd0, 15'd0, 15'($urandom), 15'($urandom), 15'h7fff};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_PHASE_STEP, steps[ph]);
            write_reg(REG_SMOOTH_MODE, 17'(modes[ph]));
            write_reg(REG_ERROR_LIMIT, 17'(elims[ph]));
            write_reg(REG_SPEED_LIMIT, 17'(slims[ph]));
            cfg_valid <= 1'b0;
            calm = (ph == 3);
            for (int k = 0; k < 55; k++) send_stim(random_stim());
            drain();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
